// File: design/d8t_pkg.sv
// Package: constants, codes, command/status types and direction decode for the D8 tracer.
`default_nettype none

package d8t_pkg;

    localparam int GRID_CELLS = 262144;
    localparam int MAX_CELLS  = 131072;
    localparam int MAX_HOPS   = 4096;

    localparam int ADDR_W  = $clog2(GRID_CELLS);
    localparam int HOP_W   = $clog2(MAX_HOPS + 1);
    localparam int FULL_W  = 21;
    localparam int COL_W   = 10;
    localparam int ROW_W   = 9;
    localparam int CODE_W  = 16;
    localparam int IDX_W   = 17;
    localparam int KIND_W  = 3;
    localparam int COLS_W  = 11;
    localparam int ROWS_W  = 10;
    localparam int CFG_W   = 2;
    localparam int POSC_W  = 13;
    localparam int POSR_W  = 12;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_MARK  = 2'd1;
    localparam logic [1:0] OP_TRACE = 2'd2;

    localparam logic [KIND_W-1:0] KIND_LINKED     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_OUTFLOW    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SINK       = 3'd2;
    localparam logic [KIND_W-1:0] KIND_UNRESOLVED = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SKIPPED    = 3'd4;

    localparam logic [CFG_W-1:0] CFG_COLUMNS = 2'd0;
    localparam logic [CFG_W-1:0] CFG_ROWS    = 2'd1;
    localparam logic [CFG_W-1:0] CFG_NODATA  = 2'd2;
    localparam logic [CFG_W-1:0] CFG_WRAP    = 2'd3;

    localparam logic [COLS_W-1:0] RST_COLUMNS = 11'd720;
    localparam logic [ROWS_W-1:0] RST_ROWS    = 10'd360;
    localparam logic signed [CODE_W-1:0] RST_NODATA = -16'sd9999;

    localparam logic signed [CODE_W-1:0] CODE_OUTFLOW = 16'sd0;
    localparam logic signed [CODE_W-1:0] CODE_SINK    = -16'sd1;
    localparam logic signed [CODE_W-1:0] DIR_E  = 16'sd1;
    localparam logic signed [CODE_W-1:0] DIR_SE = 16'sd2;
    localparam logic signed [CODE_W-1:0] DIR_S  = 16'sd4;
    localparam logic signed [CODE_W-1:0] DIR_SW = 16'sd8;
    localparam logic signed [CODE_W-1:0] DIR_W  = 16'sd16;
    localparam logic signed [CODE_W-1:0] DIR_NW = 16'sd32;
    localparam logic signed [CODE_W-1:0] DIR_N  = 16'sd64;
    localparam logic signed [CODE_W-1:0] DIR_NE = 16'sd128;

    typedef struct packed {
        logic              ok;
        logic signed [1:0] dc;
        logic signed [1:0] dr;
    } t_step;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } t_map_word;

    typedef struct packed {
        logic cap_in;
        logic addr_calc;
        logic mem_wr;
        logic clr_wr;
        logic eval;
        logic step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       clr_last;
        logic       stop;
    } t_sts;

    function automatic t_step dir_delta(input logic signed [CODE_W-1:0] v);
        t_step s;
        s.ok = 1'b1;
        s.dc = 2'sb00;
        s.dr = 2'sb00;
        case (v)
            DIR_E: begin
                s.dc = 2'sb01;
            end
            DIR_SE: begin
                s.dc = 2'sb01;
                s.dr = 2'sb11;
            end
            DIR_S: begin
                s.dr = 2'sb11;
            end
            DIR_SW: begin
                s.dc = 2'sb11;
                s.dr = 2'sb11;
            end
            DIR_W: begin
                s.dc = 2'sb11;
            end
            DIR_NW: begin
                s.dc = 2'sb11;
                s.dr = 2'sb01;
            end
            DIR_N: begin
                s.dr = 2'sb01;
            end
            DIR_NE: begin
                s.dc = 2'sb01;
                s.dr = 2'sb01;
            end
            default: begin
                s.ok = 1'b0;
            end
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// File: design/d8t_if.sv
// Interfaces: input item, result item and configuration write channels.
`default_nettype none

interface d8t_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                opcode;
    logic [9:0]                grid_col;
    logic [8:0]                grid_row;
    logic signed [15:0]        direction_code;
    logic [16:0]               cell_index;

    modport source (output valid, output opcode, output grid_col, output grid_row,
                    output direction_code, output cell_index, input ready);
    modport sink (input valid, input opcode, input grid_col, input grid_row,
                  input direction_code, input cell_index, output ready);
endinterface

interface d8t_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] source_index;
    logic [2:0]  kind;
    logic [16:0] dest_index;
    logic [9:0]  dest_col;
    logic [8:0]  dest_row;
    logic [12:0] hop_count;

    modport source (output valid, output source_index, output kind, output dest_index,
                    output dest_col, output dest_row, output hop_count, input ready);
    modport sink (input valid, input source_index, input kind, input dest_index,
                  input dest_col, input dest_row, input hop_count, output ready);
endinterface

interface d8t_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    modport source (output valid, output cfg_index, output cfg_data, input ready);
    modport sink (input valid, input cfg_index, input cfg_data, output ready);
endinterface

`default_nettype wire

// File: design/d8t_dpath.sv
// Datapath: configuration registers, position and address logic, grid memories, result register.
`default_nettype none

module d8t_dpath (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire d8t_pkg::t_cmd                       i_cmd,
    output d8t_pkg::t_sts                            o_sts,
    input  wire logic                                i_cfg_we,
    input  wire logic [d8t_pkg::CFG_W-1:0]           i_cfg_index,
    input  wire logic [d8t_pkg::CODE_W-1:0]          i_cfg_data,
    input  wire logic [1:0]                          i_opcode,
    input  wire logic [d8t_pkg::COL_W-1:0]           i_grid_col,
    input  wire logic [d8t_pkg::ROW_W-1:0]           i_grid_row,
    input  wire logic signed [d8t_pkg::CODE_W-1:0]   i_direction_code,
    input  wire logic [d8t_pkg::IDX_W-1:0]           i_cell_index,
    output logic [d8t_pkg::IDX_W-1:0]                o_source_index,
    output logic [d8t_pkg::KIND_W-1:0]               o_kind,
    output logic [d8t_pkg::IDX_W-1:0]                o_dest_index,
    output logic [d8t_pkg::COL_W-1:0]                o_dest_col,
    output logic [d8t_pkg::ROW_W-1:0]                o_dest_row,
    output logic [d8t_pkg::HOP_W-1:0]                o_hop_count
);

    logic [d8t_pkg::COLS_W-1:0]         r_cols;
    logic [d8t_pkg::ROWS_W-1:0]         r_rows;
    logic signed [d8t_pkg::CODE_W-1:0]  r_nodata;
    logic                               r_wrap;

    logic [1:0]                         r_op;
    logic [d8t_pkg::ADDR_W-1:0]         r_clr;

    logic signed [d8t_pkg::POSC_W-1:0]  r_c;
    logic signed [d8t_pkg::POSR_W-1:0]  r_r;
    logic signed [d8t_pkg::CODE_W-1:0]  r_code;
    logic [d8t_pkg::IDX_W-1:0]          r_cidx;
    logic [d8t_pkg::HOP_W-1:0]          r_hops;
    logic [d8t_pkg::ADDR_W-1:0]         r_addr;
    logic                               r_inext;
    logic [d8t_pkg::IDX_W-1:0]          r_src;
    logic [d8t_pkg::IDX_W-1:0]          r_dst;
    logic [d8t_pkg::KIND_W-1:0]         r_kind;

    logic signed [d8t_pkg::CODE_W-1:0]  r_dir_mem [0:d8t_pkg::GRID_CELLS-1];
    d8t_pkg::t_map_word                 r_map_mem [0:d8t_pkg::GRID_CELLS-1];
    logic signed [d8t_pkg::CODE_W-1:0]  r_dir_rd;
    d8t_pkg::t_map_word                 r_map_rd;

    logic signed [d8t_pkg::POSC_W-1:0]  w_cols_s;
    logic signed [d8t_pkg::POSR_W-1:0]  w_rows_s;
    logic                               w_c_in;
    logic                               w_r_in;
    logic [d8t_pkg::FULL_W-1:0]         w_prod;
    logic [d8t_pkg::FULL_W-1:0]         w_full;
    logic                               w_in_grid;

    logic                               w_hit;
    logic signed [d8t_pkg::CODE_W-1:0]  w_v;
    d8t_pkg::t_step                     w_dl;
    logic                               w_src_mode;
    logic                               w_stop;
    logic [d8t_pkg::KIND_W-1:0]         w_kind;
    logic [d8t_pkg::KIND_W-1:0]         w_nd_kind;

    logic signed [d8t_pkg::POSC_W-1:0]  w_nc_raw;
    logic signed [d8t_pkg::POSC_W-1:0]  w_nc;
    logic signed [d8t_pkg::POSR_W-1:0]  w_nr;

    logic                               w_dir_we;
    logic                               w_map_we;
    logic [d8t_pkg::ADDR_W-1:0]         w_map_wa;
    d8t_pkg::t_map_word                 w_map_wd;

    // configuration and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols   <= d8t_pkg::RST_COLUMNS;
            r_rows   <= d8t_pkg::RST_ROWS;
            r_nodata <= d8t_pkg::RST_NODATA;
            r_wrap   <= 1'b0;
            r_op     <= d8t_pkg::OP_LOAD;
            r_clr    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    d8t_pkg::CFG_COLUMNS: r_cols   <= i_cfg_data[d8t_pkg::COLS_W-1:0];
                    d8t_pkg::CFG_ROWS:    r_rows   <= i_cfg_data[d8t_pkg::ROWS_W-1:0];
                    d8t_pkg::CFG_NODATA:  r_nodata <= i_cfg_data;
                    d8t_pkg::CFG_WRAP:    r_wrap   <= i_cfg_data[0];
                    default:              r_wrap   <= r_wrap;
                endcase
            end
            if (i_cmd.cap_in) begin
                r_op <= i_opcode;
            end
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    // extent check and row-major address
    assign w_cols_s  = signed'({2'b00, r_cols});
    assign w_rows_s  = signed'({2'b00, r_rows});
    assign w_c_in    = !r_c[d8t_pkg::POSC_W-1] && (r_c < w_cols_s);
    assign w_r_in    = !r_r[d8t_pkg::POSR_W-1] && (r_r < w_rows_s);
    assign w_prod    = {11'b0, r_r[9:0]} * {10'b0, r_cols};
    assign w_full    = w_prod + {9'b0, r_c[11:0]};
    assign w_in_grid = w_full < d8t_pkg::FULL_W'(d8t_pkg::GRID_CELLS);

    // evaluate one position
    assign w_hit      = r_inext && r_map_rd.valid;
    assign w_v        = r_inext ? r_dir_rd : r_nodata;
    assign w_dl       = d8t_pkg::dir_delta(w_v);
    assign w_src_mode = (r_hops == '0);

    always_comb begin
        if (r_nodata == d8t_pkg::CODE_OUTFLOW) begin
            w_nd_kind = d8t_pkg::KIND_OUTFLOW;
        end else if (r_nodata == d8t_pkg::CODE_SINK) begin
            w_nd_kind = d8t_pkg::KIND_SINK;
        end else begin
            w_nd_kind = d8t_pkg::KIND_UNRESOLVED;
        end
    end

    always_comb begin
        w_stop = 1'b1;
        w_kind = d8t_pkg::KIND_UNRESOLVED;
        if (w_src_mode) begin
            if (!w_hit) begin
                w_kind = d8t_pkg::KIND_SKIPPED;
            end else if (w_v == r_nodata) begin
                w_kind = d8t_pkg::KIND_SKIPPED;
            end else if (w_v == d8t_pkg::CODE_OUTFLOW) begin
                w_kind = d8t_pkg::KIND_OUTFLOW;
            end else if (w_v == d8t_pkg::CODE_SINK) begin
                w_kind = d8t_pkg::KIND_SINK;
            end else if (!w_dl.ok) begin
                w_kind = d8t_pkg::KIND_SKIPPED;
            end else begin
                w_stop = 1'b0;
            end
        end else begin
            if (w_hit) begin
                w_kind = d8t_pkg::KIND_LINKED;
            end else if (w_v == d8t_pkg::CODE_OUTFLOW) begin
                w_kind = d8t_pkg::KIND_OUTFLOW;
            end else if (w_v == d8t_pkg::CODE_SINK) begin
                w_kind = d8t_pkg::KIND_SINK;
            end else if (w_v == r_nodata) begin
                w_kind = d8t_pkg::KIND_UNRESOLVED;
            end else if (r_hops >= d8t_pkg::HOP_W'(d8t_pkg::MAX_HOPS)) begin
                w_kind = d8t_pkg::KIND_UNRESOLVED;
            end else if (!w_dl.ok) begin
                w_kind = w_nd_kind;
            end else begin
                w_stop = 1'b0;
            end
        end
    end

    // next position, with east-west wrap
    assign w_nc_raw = r_c + d8t_pkg::POSC_W'(w_dl.dc);
    assign w_nr     = r_r + d8t_pkg::POSR_W'(w_dl.dr);

    always_comb begin
        if (r_wrap && (w_nc_raw < 0)) begin
            w_nc = w_cols_s - 13'sd1;
        end else if (r_wrap && (w_nc_raw >= w_cols_s)) begin
            w_nc = '0;
        end else begin
            w_nc = w_nc_raw;
        end
    end

    // walk and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_c    <= signed'({3'b000, i_grid_col});
            r_r    <= signed'({3'b000, i_grid_row});
            r_code <= i_direction_code;
            r_cidx <= i_cell_index;
            r_hops <= '0;
        end
        if (i_cmd.addr_calc) begin
            r_addr  <= w_full[d8t_pkg::ADDR_W-1:0];
            r_inext <= w_c_in && w_r_in && w_in_grid;
        end
        if (i_cmd.eval) begin
            if (w_src_mode) begin
                r_src <= w_hit ? r_map_rd.idx : '0;
            end
            if (w_stop) begin
                r_kind <= w_kind;
                r_dst  <= (!w_src_mode && w_hit) ? r_map_rd.idx : '0;
            end
        end
        if (i_cmd.step) begin
            r_c    <= w_nc;
            r_r    <= w_nr;
            r_hops <= r_hops + 1'b1;
        end
        if (i_cmd.out_load) begin
            o_source_index <= r_src;
            o_kind         <= r_kind;
            o_dest_index   <= r_dst;
            o_dest_col     <= r_c[d8t_pkg::COL_W-1:0];
            o_dest_row     <= r_r[d8t_pkg::ROW_W-1:0];
            o_hop_count    <= r_hops;
        end
    end

    // grid memories
    assign w_dir_we = i_cmd.mem_wr && (r_op == d8t_pkg::OP_LOAD) && r_inext;
    assign w_map_we = i_cmd.clr_wr
                   || (i_cmd.mem_wr && (r_op == d8t_pkg::OP_MARK) && r_inext
                       && (d8t_pkg::FULL_W'(r_cidx) < d8t_pkg::FULL_W'(d8t_pkg::MAX_CELLS)));
    assign w_map_wa = i_cmd.clr_wr ? r_clr : r_addr;
    assign w_map_wd = i_cmd.clr_wr ? '0 : {1'b1, r_cidx};

    always_ff @(posedge i_clk) begin
        if (w_dir_we) begin
            r_dir_mem[r_addr] <= r_code;
        end
        r_dir_rd <= r_dir_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_map_we) begin
            r_map_mem[w_map_wa] <= w_map_wd;
        end
        r_map_rd <= r_map_mem[w_map_wa];
    end

    always_comb begin
        o_sts.op       = r_op;
        o_sts.clr_last = (r_clr == d8t_pkg::ADDR_W'(d8t_pkg::GRID_CELLS - 1));
        o_sts.stop     = w_stop;
    end

endmodule

`default_nettype wire

// File: design/d8t_ctrl.sv
// Controller: state machine sequencing clear, load, mark and trace walks.
`default_nettype none

module d8t_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    input  wire d8t_pkg::t_sts i_sts,
    output d8t_pkg::t_cmd      o_cmd
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_ADDR  = 7'b0000100,
        S_WRITE = 7'b0001000,
        S_READ  = 7'b0010000,
        S_EVAL  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap_in = 1'b1;
                    n_state      = S_ADDR;
                end
            end
            S_ADDR: begin
                o_cmd.addr_calc = 1'b1;
                case (i_sts.op)
                    d8t_pkg::OP_TRACE: n_state = S_READ;
                    d8t_pkg::OP_LOAD:  n_state = S_WRITE;
                    d8t_pkg::OP_MARK:  n_state = S_WRITE;
                    default:           n_state = S_IDLE;
                endcase
            end
            S_WRITE: begin
                o_cmd.mem_wr = 1'b1;
                n_state      = S_IDLE;
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_sts.stop) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_ADDR;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: design/d8_downstream_tracer.sv
// Top level: D8 downstream tracer, controller plus datapath behind beat channels.
`default_nettype none

// Holds a raster of D8 direction codes and a map of model-cell positions, both in
// single-port memories addressed row * grid_columns + col. Opcode 0 loads a code,
// opcode 1 marks a model cell, opcode 2 walks downstream and returns one result beat.
// After reset the block first clears the cell map, one entry per cycle; input stays
// not ready during that pass while configuration writes are taken. A load or mark
// passes through the address and write states. In a trace each position costs one
// address multiply-add, one registered memory read and one evaluate step.
// A finished result waits in an output register, so the next beat is accepted at once;
// a trace whose result finds that register still full holds until the sink takes it.
// Configuration writes are taken every cycle and must only happen while the block is idle.
module d8_downstream_tracer (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    d8t_in_if.sink    i_in,
    d8t_out_if.source o_out,
    d8t_cfg_if.sink   i_cfg
);

    d8t_pkg::t_cmd w_cmd;
    d8t_pkg::t_sts w_sts;

    assign i_cfg.ready = 1'b1;

    d8t_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    d8t_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_cfg_we         (i_cfg.valid),
        .i_cfg_index      (i_cfg.cfg_index),
        .i_cfg_data       (i_cfg.cfg_data),
        .i_opcode         (i_in.opcode),
        .i_grid_col       (i_in.grid_col),
        .i_grid_row       (i_in.grid_row),
        .i_direction_code (i_in.direction_code),
        .i_cell_index     (i_in.cell_index),
        .o_source_index   (o_out.source_index),
        .o_kind           (o_out.kind),
        .o_dest_index     (o_out.dest_index),
        .o_dest_col       (o_out.dest_col),
        .o_dest_row       (o_out.dest_row),
        .o_hop_count      (o_out.hop_count)
    );

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_out.valid || o_out.ready))
        else $error("result register loaded over a waiting beat");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> o_out.valid)
        else $error("loaded result not presented");

    a_step_on_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.step |-> (w_cmd.eval && !w_sts.stop))
        else $error("walk advanced on a stop condition");

    a_capture_on_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.cap_in |-> (i_in.valid && i_in.ready))
        else $error("input captured without an accepted beat");
`endif

endmodule

`default_nettype wire

// File: tb/d8_tracer_checker.sv
// Checker for the D8 tracer: follows every beat, predicts trace results and compares them.
`timescale 1ns / 1ps

module d8_tracer_checker
    import d8t_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    d8t_in_if         in_ch,
    d8t_out_if        out_ch,
    d8t_cfg_if        cfg_ch,
    output int        o_errors,
    output int        o_pending
);

    typedef struct packed {
        logic [IDX_W-1:0]  source_index;
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  dest_index;
        logic [COL_W-1:0]  dest_col;
        logic [ROW_W-1:0]  dest_row;
        logic [HOP_W-1:0]  hop_count;
    } t_trace;

    logic signed [CODE_W-1:0] flow_dir [GRID_CELLS];
    logic [IDX_W-1:0]         cell_num [GRID_CELLS];
    bit                       cell_mark [GRID_CELLS];

    int                       n_cols = 720;
    int                       n_rows = 360;
    logic signed [CODE_W-1:0] nodata = RST_NODATA;
    bit                       wrap_ew = 1'b0;

    t_trace expected_traces [$];
    t_trace want;
    int     err_count = 0;
    int     addr;

    function automatic bit grid_addr(input int c, input int r, output int a);
        a = 0;
        if (c < 0 || r < 0 || c >= n_cols || r >= n_rows) return 1'b0;
        a = r * n_cols + c;
        return a < GRID_CELLS;
    endfunction

    function automatic bit heading(input logic signed [CODE_W-1:0] v, output int dc,
                                   output int dr);
        dc = 0;
        dr = 0;
        case (v)
            DIR_E: dc = 1;
            DIR_SE: begin
                dc = 1;
                dr = -1;
            end
            DIR_S: dr = -1;
            DIR_SW: begin
                dc = -1;
                dr = -1;
            end
            DIR_W: dc = -1;
            DIR_NW: begin
                dc = -1;
                dr = 1;
            end
            DIR_N: dr = 1;
            DIR_NE: begin
                dc = 1;
                dr = 1;
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic t_trace trace_downstream(input int col, input int row);
        t_trace                   res;
        int                       a, c, r, dc, dr, hops;
        logic signed [CODE_W-1:0] here, nxt;
        bit                       stop, linked, limit, inside_grid;
        res = '0;
        c = col;
        r = row;
        hops = 0;
        linked = 1'b0;
        limit = 1'b0;
        nxt = nodata;
        if (!grid_addr(c, r, a) || !cell_mark[a]) begin
            res.kind = KIND_SKIPPED;
        end else begin
            res.source_index = cell_num[a];
            here = flow_dir[a];
            if (here == nodata) begin
                res.kind = KIND_SKIPPED;
            end else if (here == CODE_OUTFLOW) begin
                res.kind = KIND_OUTFLOW;
            end else if (here == CODE_SINK) begin
                res.kind = KIND_SINK;
            end else if (!heading(here, dc, dr)) begin
                res.kind = KIND_SKIPPED;
            end else begin
                stop = 1'b0;
                while (!stop) begin
                    c += dc;
                    r += dr;
                    if (wrap_ew && c < 0) c = n_cols - 1;
                    if (wrap_ew && c >= n_cols) c = 0;
                    inside_grid = grid_addr(c, r, a);
                    nxt = inside_grid ? flow_dir[a] : nodata;
                    hops++;
                    if (inside_grid && cell_mark[a]) begin
                        linked = 1'b1;
                        res.dest_index = cell_num[a];
                        stop = 1'b1;
                    end else if (nxt == CODE_OUTFLOW || nxt == CODE_SINK || nxt == nodata) begin
                        stop = 1'b1;
                    end else if (hops >= MAX_HOPS) begin
                        limit = 1'b1;
                        stop = 1'b1;
                    end else if (!heading(nxt, dc, dr)) begin
                        nxt = nodata;
                        stop = 1'b1;
                    end
                end
                if (linked) res.kind = KIND_LINKED;
                else if (limit) res.kind = KIND_UNRESOLVED;
                else if (nxt == CODE_OUTFLOW) res.kind = KIND_OUTFLOW;
                else if (nxt == CODE_SINK) res.kind = KIND_SINK;
                else res.kind = KIND_UNRESOLVED;
            end
        end
        res.dest_col = c[COL_W-1:0];
        res.dest_row = r[ROW_W-1:0];
        res.hop_count = hops[HOP_W-1:0];
        return res;
    endfunction

    task automatic check_field(input string field, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val) begin
            $display("%0t ERROR %s: expected %0d, actual %0d", $time, field, exp_val, act_val);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            n_cols  = RST_COLUMNS;
            n_rows  = RST_ROWS;
            nodata  = RST_NODATA;
            wrap_ew = 1'b0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.cfg_index)
                    CFG_COLUMNS: n_cols = cfg_ch.cfg_data[COLS_W-1:0];
                    CFG_ROWS:    n_rows = cfg_ch.cfg_data[ROWS_W-1:0];
                    CFG_NODATA:  nodata = cfg_ch.cfg_data;
                    CFG_WRAP:    wrap_ew = cfg_ch.cfg_data[0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                if (expected_traces.size() == 0) begin
                    $display("%0t ERROR result beat with nothing expected: kind %0d at (%0d,%0d)",
                             $time, out_ch.kind, out_ch.dest_col, out_ch.dest_row);
                    err_count++;
                end else begin
                    want = expected_traces.pop_front();
                    check_field("source_index", want.source_index, out_ch.source_index);
                    check_field("kind", want.kind, out_ch.kind);
                    check_field("dest_index", want.dest_index, out_ch.dest_index);
                    check_field("dest_col", want.dest_col, out_ch.dest_col);
                    check_field("dest_row", want.dest_row, out_ch.dest_row);
                    check_field("hop_count", want.hop_count, out_ch.hop_count);
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                case (in_ch.opcode)
                    OP_LOAD: begin
                        if (grid_addr(in_ch.grid_col, in_ch.grid_row, addr))
                            flow_dir[addr] = in_ch.direction_code;
                    end
                    OP_MARK: begin
                        if (in_ch.cell_index < MAX_CELLS
                            && grid_addr(in_ch.grid_col, in_ch.grid_row, addr)) begin
                            cell_num[addr]  = in_ch.cell_index;
                            cell_mark[addr] = 1'b1;
                        end
                    end
                    OP_TRACE: begin
                        expected_traces.push_back(trace_downstream(in_ch.grid_col,
                                                                   in_ch.grid_row));
                    end
                    default: ;
                endcase
            end
        end
        o_errors  <= err_count;
        o_pending <= expected_traces.size();
    end

endmodule

// File: tb/tb_d8_downstream_tracer.sv
// Testbench top for the D8 tracer: clock, reset, grid programming, item stimulus and verdict.
`timescale 1ns / 1ps

module tb_d8_downstream_tracer;
    import d8t_pkg::*;

    localparam logic [1:0]               OP_SPARE    = 2'd3;
    localparam logic signed [CODE_W-1:0] BAD_CODE    = 16'sd3;
    localparam logic signed [CODE_W-1:0] CODE_MIN    = 16'sh8000;
    localparam logic signed [CODE_W-1:0] CODE_MAX    = 16'sh7fff;
    localparam int                       IDX_MAX     = MAX_CELLS - 1;
    localparam int                       QUIET_LIMIT = 4 * GRID_CELLS + 8 * (3 * MAX_HOPS + 5);
    localparam int                       RANDOM_ITEMS = 60;
    localparam logic signed [CODE_W-1:0] HEADINGS [8] = '{DIR_E, DIR_SE, DIR_S, DIR_SW,
                                                          DIR_W, DIR_NW, DIR_N, DIR_NE};

    logic i_clk;
    logic i_rst_n;

    d8t_in_if  in_ch ();
    d8t_out_if out_ch ();
    d8t_cfg_if cfg_ch ();

    int chk_errors;
    int chk_pending;

    logic sink_ready  = 1'b0;
    int   stall_mode  = 0;
    int   stall_span  = 0;
    int   quiet_cycles = 0;
    int   burst_left  = 0;
    int   n_items     = 0;
    int   n_traces    = 0;
    int   n_settings  = 0;

    assign out_ch.ready = sink_ready;

    d8_downstream_tracer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    d8_tracer_checker i_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_ch    (cfg_ch),
        .o_errors  (chk_errors),
        .o_pending (chk_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_span <= $urandom_range(8, 64);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            0: sink_ready <= 1'b1;
            1: sink_ready <= 1'($urandom_range(0, 1));
            default: sink_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t watchdog: no beat for %0d cycles", $time, quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_register(input logic [CFG_W-1:0] idx, input logic [15:0] data);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.cfg_index <= idx;
        cfg_ch.cfg_data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic program_grid(input int cols, input int rows,
                                input logic signed [CODE_W-1:0] nd, input bit wrap_on);
        write_register(CFG_COLUMNS, 16'(cols));
        write_register(CFG_ROWS, 16'(rows));
        write_register(CFG_NODATA, nd);
        write_register(CFG_WRAP, {15'd0, wrap_on});
        cfg_ch.valid <= 1'b0;
        n_settings++;
    endtask

    task automatic push_item(input logic [1:0] op, input int col, input int row,
                             input logic signed [CODE_W-1:0] code, input int idx);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        in_ch.valid          <= 1'b1;
        in_ch.opcode         <= op;
        in_ch.grid_col       <= col[COL_W-1:0];
        in_ch.grid_row       <= row[ROW_W-1:0];
        in_ch.direction_code <= code;
        in_ch.cell_index     <= idx[IDX_W-1:0];
        do @(posedge i_clk); while (!in_ch.ready);
        burst_left--;
        n_items++;
        if (op == OP_TRACE) n_traces++;
    endtask

    task automatic load_code(input int col, input int row, input logic signed [CODE_W-1:0] code);
        push_item(OP_LOAD, col, row, code, $urandom_range(0, IDX_MAX));
    endtask

    task automatic mark_cell(input int col, input int row, input int idx);
        push_item(OP_MARK, col, row, 16'($urandom), idx);
    endtask

    task automatic trace_from(input int col, input int row);
        push_item(OP_TRACE, col, row, 16'($urandom), $urandom_range(0, IDX_MAX));
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (chk_pending != 0);
        repeat (16) @(posedge i_clk);
    endtask

    function automatic logic signed [CODE_W-1:0] pick_code(input logic signed [CODE_W-1:0] nd);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 65) return HEADINGS[$urandom_range(0, 7)];
        if (sel < 77) return CODE_OUTFLOW;
        if (sel < 84) return CODE_SINK;
        if (sel < 91) return nd;
        return 16'($urandom);
    endfunction

    task automatic run_random_phase(input int cols, input int rows,
                                    input logic signed [CODE_W-1:0] nd, input bit wrap_on);
        int marks [$];
        int p, sel, n_marks;
        program_grid(cols, rows, nd, wrap_on);
        for (p = 0; p < cols * rows; p++) load_code(p % cols, p / cols, pick_code(nd));
        n_marks = (cols * rows + 2) / 3;
        if (n_marks > 96) n_marks = 96;
        repeat (n_marks) begin
            p = $urandom_range(0, cols * rows - 1);
            mark_cell(p % cols, p / cols, $urandom_range(0, IDX_MAX));
            marks.push_back(p);
        end
        repeat (RANDOM_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                p = marks[$urandom_range(0, marks.size() - 1)];
                trace_from(p % cols, p / cols);
            end else if (sel < 48) begin
                p = $urandom_range(0, cols * rows - 1);
                trace_from(p % cols, p / cols);
            end else if (sel < 65) begin
                p = $urandom_range(0, cols * rows - 1);
                load_code(p % cols, p / cols, pick_code(nd));
            end else if (sel < 78) begin
                p = $urandom_range(0, cols * rows - 1);
                mark_cell(p % cols, p / cols, $urandom_range(0, IDX_MAX));
                marks.push_back(p);
            end else begin
                push_item(2'($urandom_range(0, 3)), $urandom_range(0, 1023),
                          $urandom_range(0, 511), 16'($urandom), $urandom_range(0, IDX_MAX));
            end
        end
        settle();
    endtask

    initial begin
        in_ch.valid          <= 1'b0;
        in_ch.opcode         <= OP_LOAD;
        in_ch.grid_col       <= '0;
        in_ch.grid_row       <= '0;
        in_ch.direction_code <= '0;
        in_ch.cell_index     <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.cfg_index     <= CFG_COLUMNS;
        cfg_ch.cfg_data      <= '0;
        i_rst_n              <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        program_grid(8, 4, RST_NODATA, 1'b0);
        load_code(0, 0, DIR_E);
        load_code(1, 0, DIR_E);
        load_code(2, 0, CODE_OUTFLOW);
        load_code(3, 0, DIR_N);
        load_code(3, 1, CODE_SINK);
        load_code(5, 0, CODE_SINK);
        load_code(0, 3, DIR_NW);
        load_code(6, 0, DIR_N);
        load_code(6, 1, BAD_CODE);
        load_code(5, 2, RST_NODATA);
        load_code(6, 2, CODE_MIN);
        load_code(0, 1, DIR_E);
        load_code(1, 1, DIR_W);
        load_code(1, 2, DIR_S);
        load_code(7, 3, DIR_E);
        load_code(0, 2, DIR_W);
        load_code(7, 2, CODE_SINK);
        load_code(1023, 511, CODE_MAX);
        mark_cell(0, 0, 1);
        mark_cell(2, 0, IDX_MAX);
        mark_cell(3, 0, 10);
        mark_cell(5, 0, 12);
        mark_cell(0, 3, 13);
        mark_cell(6, 0, 14);
        mark_cell(5, 2, 16);
        mark_cell(6, 2, 17);
        mark_cell(1, 2, 41);
        mark_cell(7, 3, 19);
        mark_cell(0, 2, 21);
        mark_cell(7, 2, 18);
        mark_cell(8, 0, 20);
        trace_from(0, 0);
        trace_from(2, 0);
        trace_from(3, 0);
        trace_from(5, 0);
        trace_from(0, 3);
        trace_from(6, 0);
        trace_from(5, 2);
        trace_from(6, 2);
        trace_from(1, 1);
        trace_from(1023, 511);
        trace_from(8, 0);
        trace_from(1, 2);
        trace_from(7, 3);
        trace_from(0, 2);
        push_item(OP_SPARE, 3, 0, DIR_N, 5);
        mark_cell(1, 0, 30);
        mark_cell(1, 0, 31);
        trace_from(0, 0);
        settle();

        program_grid(8, 4, CODE_OUTFLOW, 1'b1);
        trace_from(0, 3);
        trace_from(6, 0);
        trace_from(7, 3);
        trace_from(0, 2);
        trace_from(5, 2);
        settle();

        program_grid(8, 4, CODE_SINK, 1'b0);
        trace_from(0, 3);
        trace_from(6, 0);
        trace_from(5, 0);
        trace_from(7, 2);
        settle();

        run_random_phase($urandom_range(2, 12), $urandom_range(2, 10), RST_NODATA, 1'b0);
        run_random_phase($urandom_range(2, 12), $urandom_range(2, 10), 16'($urandom), 1'b1);
        run_random_phase($urandom_range(2, 12), $urandom_range(2, 10), CODE_OUTFLOW, 1'b1);
        run_random_phase(1, $urandom_range(24, 48), CODE_SINK, 1'b0);
        run_random_phase($urandom_range(24, 48), 1, CODE_MIN, 1'b1);
        run_random_phase($urandom_range(1, 12), $urandom_range(1, 10), CODE_MAX,
                         1'($urandom_range(0, 1)));

        program_grid(1024, 512, RST_NODATA, 1'b1);
        load_code(1023, 255, DIR_NE);
        mark_cell(1023, 255, 0);
        trace_from(1023, 255);
        load_code(0, 0, DIR_SW);
        mark_cell(0, 0, IDX_MAX);
        trace_from(0, 0);
        mark_cell(1023, 300, 7);
        trace_from(1023, 300);
        settle();

        $display("Covered %0d items, %0d of them traces, over %0d grid settings", n_items,
                 n_traces, n_settings);
        $display("Walks reached links, outflows, sinks, extent exits, wraps and the hop limit");
        if (chk_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: files.f
design/d8t_pkg.sv
design/d8t_if.sv
design/d8t_dpath.sv
design/d8t_ctrl.sv
design/d8_downstream_tracer.sv
tb/d8_tracer_checker.sv
tb/tb_d8_downstream_tracer.sv
